/* rtl/core/brr_pkg.sv */
// Package for the budgeted round-robin refresh scheduler.
// Holds field widths, limits, register indexes and the sequencer state type.
// No dependencies.
package brr_pkg;

   localparam int MAX_ENTRIES = 4096;
   localparam int MAX_BUDGET  = 64;

   localparam int ENTRY_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int BUDGET_W   = 7;
   localparam int WEIGHT_W   = 16;
   localparam int SLOT_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS  = 2'd2;

   localparam logic FUNC_TICK       = 1'b0;
   localparam logic FUNC_INVALIDATE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/budgeted_round_robin_refresh.sv */
// Top level of the budgeted round-robin refresh scheduler.
// Holds the sequencer, the cursor, the refreshed-map memory and the CSRs.
// Depends on brr_pkg.
//
// After reset the block runs a clearing pass over the 4096-entry refreshed
// map, one entry per cycle, and takes no request until that pass ends; CSR
// writes are taken at all times. An invalidate request is taken while idle.
// A frame tick request is taken while idle and then issues its slice of
// 1..64 results at one result per cycle while the output is not stalled;
// the single map port, read and written once per emitted entry, sets that
// pace. The next request is taken while the final result still waits.
module budgeted_round_robin_refresh (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [brr_pkg::ENTRY_W-1:0]       req_probe_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [brr_pkg::ENTRY_W-1:0]       rsp_entry_index,
   output logic [brr_pkg::WEIGHT_W-1:0]      rsp_blend_weight,
   output logic [brr_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [brr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [brr_pkg::COUNT_W-1:0]  COUNT_MAX  = brr_pkg::COUNT_W'(brr_pkg::MAX_ENTRIES);
   localparam logic [brr_pkg::BUDGET_W-1:0] BUDGET_MAX = brr_pkg::BUDGET_W'(brr_pkg::MAX_BUDGET);
   localparam logic [brr_pkg::ENTRY_W-1:0]  LAST_ENTRY =
      brr_pkg::ENTRY_W'(brr_pkg::MAX_ENTRIES - 1);

   brr_pkg::state_type state_ff, state_in;

   logic [brr_pkg::COUNT_W-1:0]  probe_count_ff;
   logic [brr_pkg::BUDGET_W-1:0] budget_ff;
   logic [brr_pkg::WEIGHT_W-1:0] hysteresis_ff;

   logic [brr_pkg::ENTRY_W-1:0]  next_entry_ff, next_entry_in;
   logic [brr_pkg::ENTRY_W-1:0]  cur_ff, cur_in;
   logic [brr_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [brr_pkg::BUDGET_W-1:0] len_ff, len_in;
   logic [brr_pkg::ENTRY_W-1:0]  clr_ff, clr_in;

   logic                         out_valid_ff, out_valid_in;
   logic [brr_pkg::ENTRY_W-1:0]  out_entry_ff, out_entry_in;
   logic [brr_pkg::SLOT_W-1:0]   out_slot_ff, out_slot_in;
   logic                         out_last_ff, out_last_in;
   logic                         hit_ff;

   logic refreshed_mem [brr_pkg::MAX_ENTRIES];

   logic                         mem_we_c, mem_wdata_c, mem_re_c;
   logic [brr_pkg::ENTRY_W-1:0]  mem_addr_c;

   logic [brr_pkg::COUNT_W-1:0]  count_c, rem_c, cur_nxt_c;
   logic [brr_pkg::BUDGET_W-1:0] budget_eff_c, len_c;
   logic [brr_pkg::ENTRY_W-1:0]  start_c;
   logic                         accept_c, fire_c, last_c;

   // effective limits
   always_comb begin
      priority if (probe_count_ff == '0) begin
         count_c = brr_pkg::COUNT_W'(1);
      end else if (probe_count_ff > COUNT_MAX) begin
         count_c = COUNT_MAX;
      end else begin
         count_c = probe_count_ff;
      end
      priority if (budget_ff == '0) begin
         budget_eff_c = brr_pkg::BUDGET_W'(1);
      end else if (budget_ff > BUDGET_MAX) begin
         budget_eff_c = BUDGET_MAX;
      end else begin
         budget_eff_c = budget_ff;
      end
      start_c = ({1'b0, next_entry_ff} >= count_c) ? '0 : next_entry_ff;
      rem_c   = count_c - {1'b0, start_c};
      len_c   = ({{(brr_pkg::COUNT_W-brr_pkg::BUDGET_W){1'b0}}, budget_eff_c} > rem_c) ?
                rem_c[brr_pkg::BUDGET_W-1:0] : budget_eff_c;
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_count_ff <= brr_pkg::COUNT_W'(1);
         budget_ff      <= brr_pkg::BUDGET_W'(1);
         hysteresis_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            brr_pkg::CSR_PROBE_COUNT: probe_count_ff <= csr_wdata[brr_pkg::COUNT_W-1:0];
            brr_pkg::CSR_BUDGET:      budget_ff      <= csr_wdata[brr_pkg::BUDGET_W-1:0];
            brr_pkg::CSR_HYSTERESIS:  hysteresis_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != brr_pkg::ST_IDLE);
   assign accept_c  = req_valid && !req_stall;
   assign fire_c    = (state_ff == brr_pkg::ST_EMIT) && (!out_valid_ff || !rsp_stall);
   assign last_c    = ({1'b0, slot_ff} + brr_pkg::BUDGET_W'(1)) == len_ff;
   assign cur_nxt_c = {1'b0, cur_ff} + brr_pkg::COUNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      next_entry_in = next_entry_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      len_in        = len_ff;
      clr_in        = clr_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_entry_in  = out_entry_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      mem_we_c      = 1'b0;
      mem_wdata_c   = 1'b0;
      mem_re_c      = 1'b0;
      mem_addr_c    = cur_ff;
      unique case (state_ff)
         brr_pkg::ST_CLEAR: begin
            mem_we_c   = 1'b1;
            mem_addr_c = clr_ff;
            clr_in     = clr_ff + brr_pkg::ENTRY_W'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = brr_pkg::ST_IDLE;
            end
         end
         brr_pkg::ST_IDLE: begin
            if (accept_c) begin
               if (req_func == brr_pkg::FUNC_INVALIDATE) begin
                  mem_addr_c = req_probe_index;
                  mem_we_c   = ({1'b0, req_probe_index} < count_c);
               end else begin
                  cur_in   = start_c;
                  slot_in  = '0;
                  len_in   = len_c;
                  state_in = brr_pkg::ST_EMIT;
               end
            end
         end
         brr_pkg::ST_EMIT: begin
            if (fire_c) begin
               mem_re_c     = 1'b1;
               mem_we_c     = 1'b1;
               mem_wdata_c  = 1'b1;
               out_valid_in = 1'b1;
               out_entry_in = cur_ff;
               out_slot_in  = slot_ff;
               out_last_in  = last_c;
               cur_in       = cur_nxt_c[brr_pkg::ENTRY_W-1:0];
               slot_in      = slot_ff + brr_pkg::SLOT_W'(1);
               if (last_c) begin
                  state_in      = brr_pkg::ST_IDLE;
                  next_entry_in = (cur_nxt_c >= count_c) ? '0 :
                                  cur_nxt_c[brr_pkg::ENTRY_W-1:0];
               end
            end
         end
         default: state_in = brr_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brr_pkg::ST_CLEAR;
         next_entry_ff <= '0;
         clr_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_entry_ff <= next_entry_in;
         clr_ff        <= clr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      slot_ff      <= slot_in;
      len_ff       <= len_in;
      out_entry_ff <= out_entry_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   // read-before-write on the same port
   always_ff @(posedge clock) begin
      if (mem_re_c) begin
         hit_ff <= refreshed_mem[mem_addr_c];
      end
      if (mem_we_c) begin
         refreshed_mem[mem_addr_c] <= mem_wdata_c;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_entry_index  = out_entry_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_blend_weight = hit_ff ? hysteresis_ff : '0;

   a_entry_in_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_entry_index} < count_c))
      else $error("result entry outside the refresh set");

   a_slot_in_slice: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brr_pkg::ST_EMIT) |-> ({1'b0, slot_ff} < len_ff))
      else $error("slot counter ran past slice length");

   a_slice_continues: assert property (@(posedge clock) disable iff (reset)
      (fire_c && !last_c) |=> (state_ff == brr_pkg::ST_EMIT))
      else $error("slice ended before its final entry");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brr_pkg::ST_CLEAR) |-> !out_valid_ff)
      else $error("result pending during clearing pass");

endmodule

/* verif/tb_budgeted_round_robin_refresh.sv */
// Testbench for budgeted_round_robin_refresh: directed and random requests
// checked against a scoreboard of predicted refresh slots.
// Depends on brr_pkg and the budgeted_round_robin_refresh RTL.
module tb_budgeted_round_robin_refresh;

   localparam logic [brr_pkg::CSR_IDX_W-1:0] CSR_UNUSED = brr_pkg::CSR_IDX_W'(3);
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 800000;

   typedef struct packed {
      logic [brr_pkg::ENTRY_W-1:0]  entry_index;
      logic [brr_pkg::WEIGHT_W-1:0] blend_weight;
      logic [brr_pkg::SLOT_W-1:0]   slot;
      logic                         last;
   } refresh_slot_type;

   typedef struct {
      logic                        func;
      logic [brr_pkg::ENTRY_W-1:0] probe_index;
      bit                          drain_first;
   } request_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_func = brr_pkg::FUNC_TICK;
   logic [brr_pkg::ENTRY_W-1:0]    req_probe_index = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [brr_pkg::ENTRY_W-1:0]    rsp_entry_index;
   logic [brr_pkg::WEIGHT_W-1:0]   rsp_blend_weight;
   logic [brr_pkg::SLOT_W-1:0]     rsp_slot;
   logic                           rsp_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [brr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [brr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // scheduler shadow state
   logic [brr_pkg::COUNT_W-1:0]    cfg_probe_count = 13'd1;
   logic [brr_pkg::BUDGET_W-1:0]   cfg_budget = 7'd1;
   logic [brr_pkg::WEIGHT_W-1:0]   cfg_hysteresis = '0;
   bit [brr_pkg::MAX_ENTRIES-1:0]  refreshed_bits = '0;
   int                             cursor = 0;

   refresh_slot_type expected_refreshes[$];
   request_type      pending_requests[$];
   request_type      next_req;
   refresh_slot_type head;
   int               requests_queued = 0;
   int               requests_accepted = 0;
   int               failures = 0;
   int               idle_pct = 38;

   budgeted_round_robin_refresh dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_probe_index  (req_probe_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_blend_weight (rsp_blend_weight),
      .rsp_slot         (rsp_slot),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int active_count();
      if (cfg_probe_count == 0) return 1;
      if (cfg_probe_count > brr_pkg::MAX_ENTRIES) return brr_pkg::MAX_ENTRIES;
      return int'(cfg_probe_count);
   endfunction

   function automatic void schedule_request(input logic func,
                                            input logic [brr_pkg::ENTRY_W-1:0] idx);
      int count;
      int start;
      int len;
      int i;
      refresh_slot_type s;
      count = active_count();
      if (func == brr_pkg::FUNC_INVALIDATE) begin
         if (idx < count) refreshed_bits[idx] = 1'b0;
         return;
      end
      start = (cursor >= count) ? 0 : cursor;
      len = (cfg_budget == 0) ? 1 :
            (cfg_budget > brr_pkg::MAX_BUDGET) ? brr_pkg::MAX_BUDGET : int'(cfg_budget);
      if (len > count - start) len = count - start;
      for (i = 0; i < len; i++) begin
         s.entry_index  = brr_pkg::ENTRY_W'(start + i);
         s.blend_weight = refreshed_bits[start + i] ? cfg_hysteresis : '0;
         s.slot         = brr_pkg::SLOT_W'(i);
         s.last         = (i == len - 1);
         expected_refreshes = {expected_refreshes, s};
      end
      for (i = 0; i < len; i++) refreshed_bits[start + i] = 1'b1;
      start += len;
      cursor = (start >= count) ? 0 : start;
   endfunction

   function automatic void report_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
      failures++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endfunction

   function automatic void queue_request(input logic func, input int idx, input bit drain);
      request_type r;
      r.func        = func;
      r.probe_index = brr_pkg::ENTRY_W'(idx);
      r.drain_first = drain;
      pending_requests = {pending_requests, r};
      requests_queued++;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            schedule_request(req_func, req_probe_index);
            requests_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct &&
                (!pending_requests[0].drain_first || expected_refreshes.size() == 0)) begin
               next_req = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_func        <= next_req.func;
               req_probe_index <= next_req.probe_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_refreshes.size() == 0) begin
               failures++;
               $error("unexpected result: entry_index %0d slot %0d", rsp_entry_index, rsp_slot);
            end else begin
               head = expected_refreshes.pop_front();
               if (rsp_entry_index !== head.entry_index)
                  report_field("entry_index", head.entry_index, rsp_entry_index);
               if (rsp_blend_weight !== head.blend_weight)
                  report_field("blend_weight", head.blend_weight, rsp_blend_weight);
               if (rsp_slot !== head.slot)
                  report_field("slot", head.slot, rsp_slot);
               if (rsp_last !== head.last)
                  report_field("last", head.last, rsp_last);
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   task automatic write_csr(input logic [brr_pkg::CSR_IDX_W-1:0] idx, input int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= brr_pkg::CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         brr_pkg::CSR_PROBE_COUNT: cfg_probe_count = brr_pkg::COUNT_W'(data);
         brr_pkg::CSR_BUDGET:      cfg_budget = brr_pkg::BUDGET_W'(data);
         brr_pkg::CSR_HYSTERESIS:  cfg_hysteresis = brr_pkg::WEIGHT_W'(data);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain_block();
      while (requests_accepted != requests_queued || expected_refreshes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic randomize_config();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) write_csr(brr_pkg::CSR_PROBE_COUNT, $urandom_range(200, 1));
      else if (pick < 7) write_csr(brr_pkg::CSR_PROBE_COUNT, $urandom_range(8191));
      else if (pick < 8) write_csr(brr_pkg::CSR_PROBE_COUNT, brr_pkg::MAX_ENTRIES);
      else write_csr(brr_pkg::CSR_PROBE_COUNT, $urandom_range(8, 1));
      if ($urandom_range(99) < 20) write_csr(brr_pkg::CSR_BUDGET, $urandom_range(127));
      else write_csr(brr_pkg::CSR_BUDGET, $urandom_range(brr_pkg::MAX_BUDGET, 1));
      write_csr(brr_pkg::CSR_HYSTERESIS, $urandom_range(16'hFFFF));
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, $urandom_range(16'hFFFF));
   endtask

   task automatic run_random_phase(input int n_items, input int tick_pct);
      int k;
      bit drain;
      for (k = 0; k < n_items; k++) begin
         drain = ($urandom_range(99) < 3);
         if ($urandom_range(99) < tick_pct)
            queue_request(brr_pkg::FUNC_TICK, $urandom_range(brr_pkg::MAX_ENTRIES - 1), drain);
         else if ($urandom_range(99) < 10)
            queue_request(brr_pkg::FUNC_INVALIDATE,
                          $urandom_range(brr_pkg::MAX_ENTRIES - 1), drain);
         else
            queue_request(brr_pkg::FUNC_INVALIDATE, $urandom_range(active_count() - 1), drain);
      end
      drain_block();
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, out-of-range invalidate
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '1, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, '0, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, '1, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      drain_block();

      // slices clamped at end of set, then wrap
      write_csr(brr_pkg::CSR_PROBE_COUNT, 10);
      write_csr(brr_pkg::CSR_BUDGET, 4);
      write_csr(brr_pkg::CSR_HYSTERESIS, 16'hFFFF);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, 2, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, 10, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, '1, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b1);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      drain_block();

      // zero count and zero budget, cursor past end
      write_csr(brr_pkg::CSR_PROBE_COUNT, 0);
      write_csr(brr_pkg::CSR_BUDGET, 0);
      write_csr(brr_pkg::CSR_HYSTERESIS, 16'h0001);
      write_csr(CSR_UNUSED, 16'hFFFF);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      drain_block();

      // count and budget above their limits
      write_csr(brr_pkg::CSR_PROBE_COUNT, 8191);
      write_csr(brr_pkg::CSR_BUDGET, 127);
      write_csr(brr_pkg::CSR_HYSTERESIS, 16'h8000);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, '1, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      drain_block();

      // count lowered below cursor
      write_csr(brr_pkg::CSR_PROBE_COUNT, 50);
      write_csr(brr_pkg::CSR_BUDGET, brr_pkg::MAX_BUDGET);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_TICK, '0, 1'b0);
      queue_request(brr_pkg::FUNC_INVALIDATE, 49, 1'b0);
      drain_block();

      for (p = 0; p < 6; p++) begin
         if (p == 3) begin
            write_csr(brr_pkg::CSR_PROBE_COUNT, brr_pkg::MAX_ENTRIES);
            write_csr(brr_pkg::CSR_BUDGET, brr_pkg::MAX_BUDGET);
            write_csr(brr_pkg::CSR_HYSTERESIS, $urandom_range(16'hFFFF));
            idle_pct = 0;
            run_random_phase(72, 90);
            idle_pct = 38;
         end else begin
            randomize_config();
            run_random_phase(66, 60);
         end
      end

      repeat (64) @(posedge clock);
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
